// ===== rtl/core/hmtg_pkg.sv =====
// Shared constants, types and the vertex corner table for the terrain mesh generator.
package hmtg_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int COL_AW      = $clog2(MAX_COLUMNS);
	localparam int DIM_W       = 11;
	localparam int FIFO_DEPTH  = 2;
	localparam int VTX_PER_CELL = 6;

	// floor(p / 3) = (p * DIV3_MAGIC) >> 32, exact for p < 2^31
	localparam logic [30:0] DIV3_MAGIC = 31'h5555_5556;

	typedef enum logic [2:0] {
		REG_GRID_SPACING   = 3'd0,
		REG_HEIGHT_SCALE   = 3'd1,
		REG_CULL_THRESHOLD = 3'd2,
		REG_MAP_COLUMNS    = 3'd3,
		REG_MAP_ROWS       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]      grid_spacing;
		logic [15:0]      height_scale;
		logic [30:0]      cull_threshold;
		logic [DIM_W-1:0] map_columns;
		logic [DIM_W-1:0] map_rows;
	} cfg_t;

	// one kept cell: corner heights y0..y3, xl, xr, zt, zb, normal D term, first vertex index
	typedef struct packed {
		logic [3:0][31:0] y;
		logic [3:0][31:0] pos;
		logic [23:0]      d;
		logic [22:0]      vbase;
	} job_t;

	typedef struct packed {
		logic       xsel;
		logic       zsel;
		logic [1:0] yidx;
		logic       nsel;
	} vtx_sel_t;

	function automatic vtx_sel_t vtx_sel(input logic [2:0] k);
		vtx_sel_t s;
		unique case (k)
			3'd0:    s = '{xsel: 1'b0, zsel: 1'b0, yidx: 2'd0, nsel: 1'b0};
			3'd1:    s = '{xsel: 1'b0, zsel: 1'b1, yidx: 2'd1, nsel: 1'b0};
			3'd2:    s = '{xsel: 1'b1, zsel: 1'b0, yidx: 2'd2, nsel: 1'b0};
			3'd3:    s = '{xsel: 1'b1, zsel: 1'b0, yidx: 2'd2, nsel: 1'b1};
			3'd4:    s = '{xsel: 1'b0, zsel: 1'b1, yidx: 2'd1, nsel: 1'b1};
			3'd5:    s = '{xsel: 1'b1, zsel: 1'b1, yidx: 2'd3, nsel: 1'b1};
			default: s = '{xsel: 1'b0, zsel: 1'b0, yidx: 2'd0, nsel: 1'b0};
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/heightmap_terrain_mesh_gen.sv =====
// Top level of the streaming heightmap terrain mesh generator.
//
// Usage: height samples enter in raster order on the in_valid/in_ready channel, one item
// per grid point; start_of_map restarts row, column and vertex counters at that item.
// Each sample that closes a grid cell (row and column both at least one) yields two
// triangles, six vertex items on out_valid/out_ready, unless the cell is culled. The user
// writes registers via cfg_we/cfg_index/cfg_data only while the block is idle; unchecked.
//
// Flow: a sample that closes no cell (first row, first column) passes the front end's
// read state only; a closing sample also goes through the calculation steps and the push
// state before its job enters a two-deep queue. The front end takes no new sample until
// it is idle again. The back end runs two normals one after the other in one iterative
// unit: normalize shift, squares, bitwise square root, then the three dividers side by
// side (all skipped when grid spacing is zero). A kept cell holds the back end through
// both normals and its six vertex loads and takes no new job until the last is loaded.
//
// Reset clears counters, line-buffer neighbors and the queue and loads register defaults;
// the line buffer itself holds nothing valid until a row has been written.
// When the receiver stalls the output register holds the vertex, the back end waits,
// the queue fills and then the front end stops taking samples.
module heightmap_terrain_mesh_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         height_byte,
	input  logic               start_of_map,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               tex_u,
	output logic               tex_v,
	output logic [22:0]        vertex_number,
	output logic               last_vertex
);
	import hmtg_pkg::*;

	cfg_t cfg_q;
	logic job_valid, job_ready, pop_valid, pop_ready;
	job_t push_job, pop_job;

	// register file and its reset defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_spacing   <= 16'd256;
			cfg_q.height_scale   <= 16'd256;
			cfg_q.cull_threshold <= '0;
			cfg_q.map_columns    <= DIM_W'(1024);
			cfg_q.map_rows       <= DIM_W'(1024);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRID_SPACING:   cfg_q.grid_spacing   <= cfg_data[15:0];
				REG_HEIGHT_SCALE:   cfg_q.height_scale   <= cfg_data[15:0];
				REG_CULL_THRESHOLD: cfg_q.cull_threshold <= cfg_data;
				REG_MAP_COLUMNS:    cfg_q.map_columns    <= cfg_data[DIM_W-1:0];
				REG_MAP_ROWS:       cfg_q.map_rows       <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// sample intake, line buffer, y/position math and culling
	hmtg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.height_byte  (height_byte),
		.start_of_map (start_of_map),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (push_job)
	);

	hmtg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_job)
	);

	// normals and vertex streaming
	hmtg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (pop_valid),
		.job_ready     (pop_ready),
		.job           (pop_job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.vertex_number (vertex_number),
		.last_vertex   (last_vertex)
	);

	// the closing corner of each run is UV (1,1)
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_vertex |-> tex_u && tex_v)
		else $error("last vertex not at corner (1,1)");

	// vertical normal component comes from the non-negative grid term
	a_normal_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !normal_y[15])
		else $error("negative normal_y");

	// the front end works on one sample at a time
	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while previous one in flight");

endmodule

// ===== rtl/core/hmtg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hmtg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/hmtg_fifo.sv =====
// Short job queue between the sample front end and the vertex back end.
module hmtg_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  hmtg_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output hmtg_pkg::job_t pop_data
);
	import hmtg_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != (PTR_W+1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/hmtg_front.sv =====
// Front end: takes samples, keeps the line buffer and counters, builds and culls cell jobs.
module hmtg_front (
	input  logic           clk,
	input  logic           arst_n,
	input  hmtg_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     height_byte,
	input  logic           start_of_map,
	output logic           job_valid,
	input  logic           job_ready,
	output hmtg_pkg::job_t job
);
	import hmtg_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_READ, F_CALC, F_PUSH} fstate_t;

	fstate_t            state_q;
	logic [DIM_W-1:0]   col_q, row_q, c_q, r_q;
	logic [7:0]         cur_q, left_q, above_left_q;
	logic [3:0][7:0]    h_q;
	logic               wrap_q;
	logic [22:0]        vcount_q;
	logic [3:0]         step_q;
	logic signed [29:0] prod_q;
	logic [3:0][31:0]   y_q, pos_q;

	logic [DIM_W-1:0]   cols, rows, c_eff, r_eff, c_next, r_next;
	logic [7:0]         rd_data, above;
	logic               accept, emit, keep;
	logic signed [12:0] coef [4];
	logic signed [12:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [29:0] mul_p;
	logic [30:0]        div_in;
	logic [61:0]        div_p;
	logic signed [36:0] pos_wide;
	logic [31:0]        pos_sat;
	logic [3:0]         pidx;

	always_comb begin
		if (cfg.map_columns < DIM_W'(2)) begin
			cols = DIM_W'(2);
		end else if (cfg.map_columns > DIM_W'(MAX_COLUMNS)) begin
			cols = DIM_W'(MAX_COLUMNS);
		end else begin
			cols = cfg.map_columns;
		end
		if (cfg.map_rows < DIM_W'(2)) begin
			rows = DIM_W'(2);
		end else if (cfg.map_rows > DIM_W'(MAX_ROWS)) begin
			rows = DIM_W'(MAX_ROWS);
		end else begin
			rows = cfg.map_rows;
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign c_eff    = start_of_map ? '0 : col_q;
	assign r_eff    = start_of_map ? '0 : row_q;

	hmtg_ram #(.WIDTH(8), .DEPTH(MAX_COLUMNS)) u_line (
		.clk   (clk),
		.we    ((state_q == F_READ) && (c_q < MAX_COLUMNS)),
		.waddr (c_q[COL_AW-1:0]),
		.wdata (cur_q),
		.re    (accept),
		.raddr (c_eff[COL_AW-1:0]),
		.rdata (rd_data)
	);

	assign above  = (c_q < MAX_COLUMNS) ? rd_data : 8'd0;
	assign emit   = (r_q >= DIM_W'(1)) && (c_q >= DIM_W'(1)) && (r_q < rows) && (c_q < cols);
	assign c_next = c_q + 1'b1;
	assign r_next = r_q + 1'b1;

	// grid coefficients 2c-1-C, 2c+1-C, 2r-1-R, 2r+1-R
	assign coef[0] = $signed({1'b0, c_q, 1'b0}) - 13'sd1 - $signed({2'b0, cols});
	assign coef[1] = $signed({1'b0, c_q, 1'b0}) + 13'sd1 - $signed({2'b0, cols});
	assign coef[2] = $signed({1'b0, r_q, 1'b0}) - 13'sd1 - $signed({2'b0, rows});
	assign coef[3] = $signed({1'b0, r_q, 1'b0}) + 13'sd1 - $signed({2'b0, rows});

	always_comb begin
		if (!step_q[2]) begin
			mul_a = $signed({5'b0, h_q[step_q[1:0]]});
			mul_b = $signed({1'b0, cfg.height_scale});
		end else begin
			mul_a = coef[step_q[1:0]];
			mul_b = $signed({1'b0, cfg.grid_spacing});
		end
	end
	assign mul_p = mul_a * mul_b;

	// y = floor(h*s*128/3)
	assign div_in   = {prod_q[23:0], 7'b0};
	assign div_p    = div_in * DIV3_MAGIC;
	assign pos_wide = {prod_q, 7'b0};
	assign pidx     = step_q - 4'd1;

	always_comb begin
		if (pos_wide[36:31] != {6{pos_wide[36]}}) begin
			pos_sat = pos_wide[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			pos_sat = pos_wide[31:0];
		end
	end

	always_comb begin
		keep = (cfg.cull_threshold == '0);
		if ((y_q[0][30:0] >= cfg.cull_threshold) && (y_q[1][30:0] >= cfg.cull_threshold) &&
		    (y_q[2][30:0] >= cfg.cull_threshold) && (y_q[3][30:0] >= cfg.cull_threshold)) begin
			keep = 1'b1;
		end
	end

	assign job_valid = (state_q == F_PUSH) && keep;
	assign job.y     = y_q;
	assign job.pos   = pos_q;
	assign job.d     = {cfg.grid_spacing, 8'b0};
	assign job.vbase = vcount_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= height_byte;
		end
		if (state_q == F_READ) begin
			h_q <= {cur_q, above, left_q, above_left_q};
		end
		if (state_q == F_CALC) begin
			prod_q <= mul_p;
			if (step_q != 4'd0) begin
				if (!pidx[2]) begin
					y_q[pidx[1:0]] <= {2'b0, div_p[61:32]};
				end else begin
					pos_q[pidx[1:0]] <= pos_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			c_q          <= '0;
			r_q          <= '0;
			left_q       <= '0;
			above_left_q <= '0;
			wrap_q       <= 1'b0;
			vcount_q     <= '0;
			step_q       <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						c_q <= c_eff;
						r_q <= r_eff;
						if (start_of_map) begin
							vcount_q <= '0;
						end
						state_q <= F_READ;
					end
				end
				F_READ: begin
					above_left_q <= above;
					left_q       <= cur_q;
					wrap_q       <= 1'b0;
					if (c_next >= cols) begin
						col_q <= '0;
						if (r_next >= rows) begin
							row_q  <= '0;
							wrap_q <= 1'b1;
						end else begin
							row_q <= r_next;
						end
					end else begin
						col_q <= c_next;
						row_q <= r_q;
					end
					if (emit) begin
						step_q  <= '0;
						state_q <= F_CALC;
					end else begin
						if ((c_next >= cols) && (r_next >= rows)) begin
							vcount_q <= '0;
						end
						state_q <= F_IDLE;
					end
				end
				F_CALC: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd8) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!keep) begin
						if (wrap_q) begin
							vcount_q <= '0;
						end
						state_q <= F_IDLE;
					end else if (job_ready) begin
						vcount_q <= wrap_q ? '0 : vcount_q + 23'(VTX_PER_CELL);
						state_q  <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/hmtg_norm.sv =====
// Iterative unit normal: normalize shift, sum of squares, bitwise square root, three dividers.
module hmtg_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic [23:0]        d,
	output logic               done,
	output logic [2:0][15:0]   n
);
	import hmtg_pkg::*;

	typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_PREP, N_DIV} nstate_t;

	nstate_t          state_q;
	logic [2:0][30:0] m_q;
	logic [2:0]       neg_q;
	logic [4:0]       cnt_q;
	logic [61:0]      sq_q;
	logic [63:0]      sum_q, res_q, bit_q;
	logic [46:0]      dv_q;
	logic [2:0][45:0] rem_q;
	logic [2:0][15:0] quo_q;
	logic             done_q;
	logic [2:0][15:0] n_q;

	logic [31:0]      abs_a, abs_b;
	logic [30:0]      m_sel;
	logic [61:0]      sq_mul;
	logic [63:0]      trial;
	logic [2:0]       ge;
	logic [2:0][45:0] rem_sub;
	logic [2:0][15:0] quo_next;

	assign done  = done_q;
	assign n     = n_q;
	assign abs_a = a[31] ? 32'(-a) : a;
	assign abs_b = b[31] ? 32'(-b) : b;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    m_sel = m_q[0];
			2'd1:    m_sel = m_q[1];
			2'd2:    m_sel = m_q[2];
			default: m_sel = '0;
		endcase
	end
	assign sq_mul = m_sel * m_sel;
	assign trial  = res_q + bit_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ge[k]       = ({1'b0, rem_q[k]} >= dv_q);
			rem_sub[k]  = 46'({1'b0, rem_q[k]} - dv_q);
			quo_next[k] = {quo_q[k][14:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (start) begin
					m_q   <= {abs_b[30:0], {7'b0, d}, abs_a[30:0]};
					neg_q <= {b[31], 1'b0, a[31]};
				end
			end
			N_SHIFT: begin
				if (((m_q[0] | m_q[1] | m_q[2]) & 31'h6000_0000) == '0) begin
					for (int k = 0; k < 3; k++) begin
						m_q[k] <= {m_q[k][29:0], 1'b0};
					end
				end
			end
			N_SQ: begin
				sq_q  <= sq_mul;
				sum_q <= (cnt_q == 5'd0) ? '0 : sum_q + {2'b0, sq_q};
			end
			N_SQRT: begin
				if (sum_q >= trial) begin
					sum_q <= sum_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_PREP: begin
				dv_q <= {res_q[31:0], 15'b0};
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= {1'b0, m_q[k], 14'b0} + {14'b0, res_q[32:1]};
					quo_q[k] <= '0;
				end
			end
			N_DIV: begin
				dv_q <= dv_q >> 1;
				for (int k = 0; k < 3; k++) begin
					if (ge[k]) begin
						rem_q[k] <= rem_sub[k];
					end
					quo_q[k] <= quo_next[k];
				end
			end
			default: ;
		endcase
		if ((state_q == N_SQ) && (cnt_q == 5'd3)) begin
			res_q <= '0;
			bit_q <= 64'h1 << 62;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						if (d == '0) begin
							n_q    <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					if (((m_q[0] | m_q[1] | m_q[2]) & 31'h6000_0000) != '0) begin
						cnt_q   <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= N_PREP;
					end
				end
				N_PREP: begin
					cnt_q   <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd15) begin
						for (int k = 0; k < 3; k++) begin
							n_q[k] <= neg_q[k] ? 16'(-quo_next[k]) : quo_next[k];
						end
						done_q  <= 1'b1;
						state_q <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/hmtg_back.sv =====
// Back end: pops cell jobs, runs both face normals, streams six vertices through an output register.
module hmtg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  hmtg_pkg::job_t     job,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               tex_u,
	output logic               tex_v,
	output logic [22:0]        vertex_number,
	output logic               last_vertex
);
	import hmtg_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_N1, B_N2, B_EMIT} bstate_t;

	bstate_t            state_q;
	job_t               job_q;
	logic [2:0][15:0]   n1_q, n2_q;
	logic [2:0]         k_q;
	logic               out_valid_q;

	logic               norm_start, norm_done;
	logic signed [31:0] norm_a, norm_b;
	logic [23:0]        norm_d;
	logic [2:0][15:0]   norm_n, nsel;
	logic               load;
	vtx_sel_t           sel;

	assign job_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		if (state_q == B_IDLE) begin
			norm_a = $signed(job.y[0]) - $signed(job.y[2]);
			norm_b = $signed(job.y[0]) - $signed(job.y[1]);
			norm_d = job.d;
		end else begin
			norm_a = $signed(job_q.y[1]) - $signed(job_q.y[3]);
			norm_b = $signed(job_q.y[2]) - $signed(job_q.y[3]);
			norm_d = job_q.d;
		end
	end
	assign norm_start = ((state_q == B_IDLE) && job_valid) || ((state_q == B_N1) && norm_done);

	hmtg_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.a      (norm_a),
		.b      (norm_b),
		.d      (norm_d),
		.done   (norm_done),
		.n      (norm_n)
	);

	assign load = (state_q == B_EMIT) && (!out_valid_q || out_ready);
	assign sel  = vtx_sel(k_q);
	assign nsel = sel.nsel ? n2_q : n1_q;

	always_ff @(posedge clk) begin
		if ((state_q == B_IDLE) && job_valid) begin
			job_q <= job;
		end
		if ((state_q == B_N1) && norm_done) begin
			n1_q <= norm_n;
		end
		if ((state_q == B_N2) && norm_done) begin
			n2_q <= norm_n;
		end
		if (load) begin
			pos_x         <= sel.xsel ? job_q.pos[1] : job_q.pos[0];
			pos_y         <= job_q.y[sel.yidx];
			pos_z         <= sel.zsel ? job_q.pos[3] : job_q.pos[2];
			normal_x      <= nsel[0];
			normal_y      <= nsel[1];
			normal_z      <= nsel[2];
			tex_u         <= sel.xsel;
			tex_v         <= sel.zsel;
			vertex_number <= job_q.vbase + 23'(k_q);
			last_vertex   <= (k_q == 3'(VTX_PER_CELL - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= B_N1;
					end
				end
				B_N1: begin
					if (norm_done) begin
						state_q <= B_N2;
					end
				end
				B_N2: begin
					if (norm_done) begin
						k_q     <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + 1'b1;
						if (k_q == 3'(VTX_PER_CELL - 1)) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
